>>> rtl/sdtl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdtl_pkg
// Shared types, codes and defaults of the sorted deadline timer list.
// ----------------------------------------------------------------------------
package sdtl_pkg;

    localparam int MAX_TIMERS_DEF = 64;
    localparam int TIME_BITS_DEF  = 32;
    localparam int SLOT_BITS      = 6;
    localparam int IN_TIME_BITS   = 32;
    localparam int LINK_BITS      = 7;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_ADJUST = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_LINKED     = 2'd1,
        ST_NOT_LINKED = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]              command;
        logic [SLOT_BITS-1:0]    slot;
        logic [IN_TIME_BITS-1:0] time_value;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_BITS-1:0] expired_slot;
        logic                 expired_valid;
        logic [1:0]           status;
        logic                 last;
    } out_item_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,     // capture input item
        OP_RD_SLOT,   // issue reads at slot
        OP_RD_HEAD,   // issue reads at head
        OP_RD_CUR,    // issue reads at cursor
        OP_UNLINK_P,  // fix predecessor side of unlink
        OP_UNLINK_N,  // fix successor side of unlink
        OP_SET_TIME,  // store new time of slot
        OP_WALK,      // step cursor to next
        OP_INS_S,     // write links of slot
        OP_INS_P,     // write next of predecessor / head
        OP_INS_N,     // write prev of successor / tail
        OP_START_N,   // set search start at former successor
        OP_CAP_LINKS  // capture links of read target
    } op_t;

    typedef struct packed {
        op_t op;
    } ctl_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       slot_ok;
        logic       slot_linked;
        logic       head_nil;
        logic       cur_nil;
        logic       cur_le;      // cursor time <= time of item
        logic       next_nil;    // successor of slot is null
        logic       ge_next;     // new time >= successor time
        logic       guard_done;
    } sts_t;

endpackage
`default_nettype wire

>>> rtl/sdtl_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdtl_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sdtl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> rtl/sdtl_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdtl_datapath
// Link and time memories, head and tail, linked flags and list cursors.
// ----------------------------------------------------------------------------
module sdtl_datapath
    import sdtl_pkg::*;
#(
    parameter int MAX_TIMERS = MAX_TIMERS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire in_item_t in_item,
    input  wire ctl_t     ctl,
    output sts_t          sts,
    output logic [SLOT_BITS-1:0] head_out
);
    localparam int AW = $clog2(MAX_TIMERS);
    localparam logic [LINK_BITS-1:0] NIL = LINK_BITS'(64);
    localparam int GW = $clog2(MAX_TIMERS + 1);

    logic [1:0]             cmd_reg;
    logic [SLOT_BITS-1:0]   slot_reg;
    logic [TIME_BITS-1:0]   t_reg;
    logic [LINK_BITS-1:0]   head_reg, tail_reg;
    logic [MAX_TIMERS-1:0]  linked_reg;
    logic [LINK_BITS-1:0]   p_reg, cur_reg, sp_reg, sn_reg;
    logic [GW-1:0]          guard_reg;
    logic [LINK_BITS-1:0]   tgt_reg;   // slot whose links were read

    // memories
    logic                 t_we, n_we, p_we;
    logic [AW-1:0]        t_wa, n_wa, p_wa, raddr;
    logic [TIME_BITS-1:0] t_wd, t_rd;
    logic [LINK_BITS-1:0] n_wd, p_wd, n_rd, p_rd;

    sdtl_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_TIMERS)) u_time (
        .aclk(aclk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(raddr), .rdata(t_rd));
    sdtl_ram #(.WIDTH(LINK_BITS), .DEPTH(MAX_TIMERS)) u_next (
        .aclk(aclk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(raddr), .rdata(n_rd));
    sdtl_ram #(.WIDTH(LINK_BITS), .DEPTH(MAX_TIMERS)) u_prev (
        .aclk(aclk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(raddr), .rdata(p_rd));

    function automatic logic lnk_ok(input logic [LINK_BITS-1:0] v);
        return {{(32-LINK_BITS){1'b0}}, v} < MAX_TIMERS;
    endfunction

    logic slot_ok;
    assign slot_ok = {{(32-SLOT_BITS){1'b0}}, slot_reg} < MAX_TIMERS;
    logic [AW-1:0] s_idx;
    assign s_idx = slot_reg[AW-1:0];

    always_comb begin
        raddr = tgt_reg[AW-1:0];
        t_we = 1'b0; n_we = 1'b0; p_we = 1'b0;
        t_wa = s_idx; n_wa = s_idx; p_wa = s_idx;
        t_wd = t_reg; n_wd = NIL; p_wd = NIL;
        case (ctl.op)
            OP_RD_SLOT: raddr = s_idx;
            OP_RD_HEAD: raddr = head_reg[AW-1:0];
            OP_RD_CUR:  raddr = cur_reg[AW-1:0];
            OP_WALK:    raddr = n_rd[AW-1:0];
            OP_SET_TIME: t_we = 1'b1;
            OP_UNLINK_P: begin
                n_we = lnk_ok(sp_reg);
                n_wa = sp_reg[AW-1:0];
                n_wd = sn_reg;
            end
            OP_UNLINK_N: begin
                p_we = lnk_ok(sn_reg);
                p_wa = sn_reg[AW-1:0];
                p_wd = sp_reg;
            end
            OP_INS_S: begin
                n_we = 1'b1; p_we = 1'b1;
                n_wd = lnk_ok(cur_reg) ? cur_reg : NIL;
                p_wd = p_reg;
            end
            OP_INS_P: begin
                n_we = lnk_ok(p_reg);
                n_wa = p_reg[AW-1:0];
                n_wd = LINK_BITS'(slot_reg);
            end
            OP_INS_N: begin
                p_we = lnk_ok(cur_reg);
                p_wa = cur_reg[AW-1:0];
                p_wd = LINK_BITS'(slot_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= NIL;
            tail_reg   <= NIL;
            linked_reg <= '0;
        end else begin
            case (ctl.op)
                OP_LATCH: begin
                    cmd_reg  <= in_item.command;
                    slot_reg <= in_item.slot;
                    t_reg    <= TIME_BITS'(in_item.time_value);
                end
                OP_RD_SLOT: begin
                    tgt_reg <= LINK_BITS'(slot_reg);
                end
                OP_RD_HEAD: begin
                    tgt_reg <= head_reg;
                    p_reg   <= NIL;
                    cur_reg <= head_reg;
                    guard_reg <= '0;
                end
                OP_RD_CUR: begin
                    tgt_reg <= cur_reg;
                end
                OP_WALK: begin
                    p_reg     <= cur_reg;
                    cur_reg   <= n_rd;
                    tgt_reg   <= n_rd;
                    guard_reg <= guard_reg + 1'b1;
                end
                OP_UNLINK_P: begin
                    // links of the slot being unlinked are in sp_reg and sn_reg from an earlier capture
                    if (!lnk_ok(sp_reg)) head_reg <= sn_reg;
                end
                OP_UNLINK_N: begin
                    if (!lnk_ok(sn_reg)) tail_reg <= sp_reg;
                    if (cmd_reg == CMD_TICK) begin
                        linked_reg[tgt_reg[AW-1:0]] <= 1'b0;
                    end else begin
                        linked_reg[s_idx] <= 1'b0;
                    end
                end
                OP_INS_P: begin
                    if (!lnk_ok(p_reg)) head_reg <= LINK_BITS'(slot_reg);
                end
                OP_INS_N: begin
                    if (!lnk_ok(cur_reg)) tail_reg <= LINK_BITS'(slot_reg);
                    linked_reg[s_idx] <= 1'b1;
                end
                OP_START_N: begin
                    p_reg     <= sn_reg;
                    guard_reg <= '0;
                end
                default: ;
            endcase
            // capture links of read target in the cycle after its read
            if (ctl.op == OP_CAP_LINKS) begin
                sp_reg <= p_rd;
                sn_reg <= n_rd;
            end
            // adjust: search from former successor; cursor starts on it
            if (ctl.op == OP_START_N) begin
                cur_reg <= n_rd;
            end
        end
    end

    assign sts.cmd         = cmd_reg;
    assign sts.slot_ok     = slot_ok;
    assign sts.slot_linked = slot_ok && linked_reg[s_idx];
    assign sts.head_nil    = !lnk_ok(head_reg);
    assign sts.cur_nil     = !lnk_ok(cur_reg);
    assign sts.cur_le      = t_rd <= t_reg;
    assign sts.next_nil    = !lnk_ok(n_rd);
    assign sts.ge_next     = t_reg >= t_rd;
    assign sts.guard_done  = {{(32-GW){1'b0}}, guard_reg} >= MAX_TIMERS;
    assign head_out        = SLOT_BITS'(head_reg);
endmodule
`default_nettype wire

>>> rtl/sdtl_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdtl_ctrl
// Command sequencer: decode, list walk, unlink and insert steps, results.
// ----------------------------------------------------------------------------
module sdtl_ctrl
    import sdtl_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_item_t     m_data,
    input  wire sts_t     sts,
    input  wire logic [SLOT_BITS-1:0] head_slot,
    output ctl_t          ctl
);
    typedef enum logic [4:0] {
        S_IDLE, S_DECODE,
        S_TK_RD, S_TK_WAIT, S_TK_CHK, S_TK_CAP, S_TK_UP, S_TK_UN, S_TK_OUT,
        S_UL_RD, S_UL_WAIT, S_UL_CAP, S_UL_P, S_UL_N,
        S_AJ_WAIT, S_AJ_CAP, S_AJ_TRD, S_AJ_TWAIT, S_AJ_CHK, S_AJ_SET,
        S_AJ_NRD, S_AJ_NWAIT,
        S_IN_WAIT, S_IN_CHK, S_IN_S, S_IN_P, S_IN_N,
        S_OUT
    } state_t;

    state_t    state_reg, state_next;
    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;
    out_item_t hold_reg, hold_next;   // expired beat waiting for its last flag
    logic      tick_any_reg, tick_any_next;
    logic      adj_reg, adj_next;
    logic      m_free;
    op_t       op;

    assign m_free  = !m_valid_reg || m_ready;
    assign s_ready = aresetn && (state_reg == S_IDLE) && m_free;

    always_comb begin
        state_next    = state_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        hold_next     = hold_reg;
        tick_any_next = tick_any_reg;
        adj_next      = adj_reg;
        op            = OP_NONE;
        case (state_reg)
            S_IDLE: begin
                if (s_valid && m_free) begin
                    op = OP_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                m_data_next = '{expired_slot: '0, expired_valid: 1'b0,
                                status: ST_OK, last: 1'b1};
                tick_any_next = 1'b0;
                if (sts.cmd == CMD_TICK) begin
                    state_next = S_TK_CHK;
                end else if (!sts.slot_ok) begin
                    m_data_next.status = ST_NOT_LINKED;
                    state_next = S_OUT;
                end else if (sts.cmd == CMD_ADD) begin
                    if (sts.slot_linked) begin
                        m_data_next.status = ST_LINKED;
                        state_next = S_OUT;
                    end else begin
                        op = OP_SET_TIME;
                        adj_next = 1'b0;
                        state_next = S_IN_WAIT;
                    end
                end else if (!sts.slot_linked) begin
                    m_data_next.status = ST_NOT_LINKED;
                    state_next = S_OUT;
                end else if (sts.cmd == CMD_ADJUST) begin
                    op = OP_RD_SLOT;
                    state_next = S_AJ_WAIT;
                end else begin
                    op = OP_RD_SLOT;
                    state_next = S_UL_WAIT;
                end
            end
            // tick: head expiry loop
            S_TK_CHK: begin
                if (sts.head_nil) begin
                    state_next = S_TK_OUT;
                end else begin
                    op = OP_RD_HEAD;
                    state_next = S_TK_WAIT;
                end
            end
            S_TK_WAIT: begin
                op = OP_CAP_LINKS;
                state_next = S_TK_CAP;
            end
            S_TK_CAP: begin
                if (sts.cur_le) begin
                    if (m_free) begin
                        if (tick_any_reg) begin
                            m_valid_next = 1'b1;
                            m_data_next  = hold_reg;
                        end
                        hold_next = '{expired_slot: head_slot, expired_valid: 1'b1,
                                      status: ST_OK, last: 1'b0};
                        tick_any_next = 1'b1;
                        op = OP_UNLINK_P;
                        state_next = S_TK_UN;
                    end
                end else begin
                    state_next = S_TK_OUT;
                end
            end
            S_TK_UN: begin
                op = OP_UNLINK_N;
                state_next = S_TK_CHK;
            end
            S_TK_OUT: begin
                if (m_free) begin
                    if (!tick_any_reg) begin
                        m_data_next = '{expired_slot: '0, expired_valid: 1'b0,
                                        status: ST_OK, last: 1'b1};
                    end else begin
                        m_data_next = hold_reg;
                        m_data_next.last = 1'b1;
                    end
                    m_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            // delete
            S_UL_WAIT: begin
                op = OP_CAP_LINKS;
                state_next = S_UL_P;
            end
            S_UL_P: begin
                op = OP_UNLINK_P;
                state_next = S_UL_N;
            end
            S_UL_N: begin
                op = OP_UNLINK_N;
                state_next = S_OUT;
            end
            // adjust: links of slot are read, then successor time
            S_AJ_WAIT: begin
                op = OP_CAP_LINKS;
                state_next = S_AJ_CAP;
            end
            S_AJ_CAP: begin
                if (sts.next_nil) begin
                    op = OP_SET_TIME;
                    state_next = S_OUT;
                end else begin
                    op = OP_START_N;
                    state_next = S_AJ_TRD;
                end
            end
            S_AJ_TRD: begin
                op = OP_RD_CUR;
                state_next = S_AJ_TWAIT;
            end
            S_AJ_TWAIT: state_next = S_AJ_CHK;
            S_AJ_CHK: begin
                op = OP_SET_TIME;
                if (sts.ge_next) begin
                    state_next = S_AJ_SET;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_AJ_SET: begin
                op = OP_UNLINK_P;
                state_next = S_AJ_NRD;
            end
            S_AJ_NRD: begin
                op = OP_UNLINK_N;
                adj_next = 1'b1;
                state_next = S_AJ_NWAIT;
            end
            S_AJ_NWAIT: begin
                op = OP_RD_CUR;
                state_next = S_IN_CHK;
            end
            // insert walk
            S_IN_WAIT: begin
                op = OP_RD_HEAD;
                state_next = S_IN_CHK;
            end
            S_IN_CHK: begin
                if (sts.cur_nil || sts.guard_done) begin
                    state_next = S_IN_S;
                end else begin
                    state_next = S_TK_UP;
                end
            end
            S_TK_UP: begin
                if (sts.cur_le) begin
                    op = OP_WALK;
                    state_next = S_IN_CHK;
                end else begin
                    state_next = S_IN_S;
                end
            end
            S_IN_S: begin
                op = OP_INS_S;
                state_next = S_IN_P;
            end
            S_IN_P: begin
                op = OP_INS_P;
                state_next = S_IN_N;
            end
            S_IN_N: begin
                op = OP_INS_N;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_free) begin
                    m_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_valid_reg  <= 1'b0;
            tick_any_reg <= 1'b0;
            adj_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            tick_any_reg <= tick_any_next;
            adj_reg      <= adj_next;
        end
        m_data_reg <= m_data_next;
        hold_reg   <= hold_next;
    end

    assign ctl.op  = op;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
endmodule
`default_nettype wire

>>> rtl/sorted_deadline_timer_list.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_deadline_timer_list
// Timer slots kept in a linked list sorted by expiry time, with tick expiry.
// ----------------------------------------------------------------------------
// Commands are taken one at a time. Add walks the list from the head; an
// adjust that moves its timer walks on from the former successor. Tick
// expires timers from the head and emits one beat per expired timer, the
// final beat marked last, or one beat with no expired slot if none expire.
// Each walk step is bound by a registered read of the link and time
// memories; a stalled result beat holds the sequencer.
module sorted_deadline_timer_list
    import sdtl_pkg::*;
#(
    parameter int MAX_TIMERS = MAX_TIMERS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);
    ctl_t ctl;
    sts_t sts;
    logic [SLOT_BITS-1:0] head_slot;

    sdtl_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .sts(sts), .head_slot(head_slot), .ctl(ctl));

    sdtl_datapath #(.MAX_TIMERS(MAX_TIMERS), .TIME_BITS(TIME_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .in_item(s_data),
        .ctl(ctl), .sts(sts), .head_out(head_slot));
endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted deadline timer list. Add, adjust, delete
// and tick beats are driven with random gaps; every result beat is compared
// with a scoreboard fed by a behavioral copy of the sorted list.
// ----------------------------------------------------------------------------
module tb_top;
    import sdtl_pkg::*;

    localparam int NSLOT = 64;
    localparam int NIL   = 64;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    sorted_deadline_timer_list dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // behavioral copy of the list
    logic [31:0] tm_time [NSLOT];
    logic        tm_linked [NSLOT];
    int          tm_next [NSLOT];
    int          tm_prev [NSLOT];
    int          tm_head;
    int          tm_tail;

    in_item_t  pending_beats [$];
    out_item_t expected_beats [$];
    int        fail_count;
    int        send_idle;
    int        recv_idle;

    // accept flag captured at the rising edge
    logic s_ready_seen;

    task automatic list_unlink(input int s);
        int p;
        int n;
        begin
            p = tm_prev[s];
            n = tm_next[s];
            if (p != NIL) tm_next[p] = n; else tm_head = n;
            if (n != NIL) tm_prev[n] = p; else tm_tail = p;
            tm_next[s] = NIL;
            tm_prev[s] = NIL;
            tm_linked[s] = 1'b0;
        end
    endtask

    task automatic list_insert(input int s, input int start);
        int p;
        int cur;
        int guard;
        begin
            p = start;
            cur = (p != NIL) ? tm_next[p] : tm_head;
            guard = 0;
            while (cur != NIL && guard < NSLOT && tm_time[cur] <= tm_time[s]) begin
                p = cur;
                cur = tm_next[cur];
                guard++;
            end
            tm_prev[s] = p;
            tm_next[s] = cur;
            if (p != NIL) tm_next[p] = s; else tm_head = s;
            if (cur != NIL) tm_prev[cur] = s; else tm_tail = s;
            tm_linked[s] = 1'b1;
        end
    endtask

    task automatic predict_timer_beat(input in_item_t it);
        out_item_t r;
        int s;
        int n;
        int k;
        begin
            s = int'(it.slot);
            r = '0;
            r.last = 1'b1;
            r.status = ST_OK;
            if (cmd_t'(it.command) == CMD_TICK) begin
                k = 0;
                while (tm_head != NIL && k < NSLOT && tm_time[tm_head] <= it.time_value) begin
                    r.expired_slot = tm_head[5:0];
                    r.expired_valid = 1'b1;
                    r.last = 1'b0;
                    expected_beats.push_back(r);
                    list_unlink(tm_head);
                    k++;
                end
                if (k == 0) begin
                    expected_beats.push_back(r);
                end else begin
                    r = expected_beats.pop_back();
                    r.last = 1'b1;
                    expected_beats.push_back(r);
                end
            end else begin
                if (cmd_t'(it.command) == CMD_ADD) begin
                    if (tm_linked[s]) begin
                        r.status = ST_LINKED;
                    end else begin
                        tm_time[s] = it.time_value;
                        list_insert(s, NIL);
                    end
                end else if (!tm_linked[s]) begin
                    r.status = ST_NOT_LINKED;
                end else if (cmd_t'(it.command) == CMD_ADJUST) begin
                    n = tm_next[s];
                    tm_time[s] = it.time_value;
                    if (n != NIL && it.time_value >= tm_time[n]) begin
                        list_unlink(s);
                        list_insert(s, n);
                    end
                end else begin
                    list_unlink(s);
                end
                expected_beats.push_back(r);
            end
        end
    endtask

    function automatic in_item_t make_beat(input cmd_t c, input int s, input logic [31:0] t);
        in_item_t it;
        begin
            it.command = c;
            it.slot = s[5:0];
            it.time_value = t;
            return it;
        end
    endfunction

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready_seen) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle) begin
                s_data <= pending_beats.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge aclk) begin
        s_ready_seen <= s_valid && s_ready && aresetn;
        if (aresetn && s_valid && s_ready) predict_timer_beat(s_data);
    end

    // monitor
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_beats.size() == 0) begin
                $error("unexpected result beat %p", m_data);
                fail_count++;
            end else begin
                want = expected_beats.pop_front();
                if (m_data.expired_slot !== want.expired_slot) begin
                    $error("expired_slot exp %0d got %0d", want.expired_slot, m_data.expired_slot);
                    fail_count++;
                end
                if (m_data.expired_valid !== want.expired_valid) begin
                    $error("expired_valid exp %0d got %0d",
                           want.expired_valid, m_data.expired_valid);
                    fail_count++;
                end
                if (m_data.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, m_data.status);
                    fail_count++;
                end
                if (m_data.last !== want.last) begin
                    $error("last exp %0d got %0d", want.last, m_data.last);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic [31:0] rand_time(input logic [31:0] base);
        int sel;
        begin
            sel = $urandom_range(9);
            if (sel == 0) return 32'hFFFF_FFFF;
            if (sel == 1) return 32'h0;
            if (sel == 2) return $urandom();
            return base + $urandom_range(60);
        end
    endfunction

    task automatic wait_drained;
        begin
            while (pending_beats.size() != 0 || s_valid || expected_beats.size() != 0)
                @(posedge aclk);
            repeat (200) @(posedge aclk);
        end
    endtask

    initial begin
        logic [31:0] now;
        int phase;
        int i;
        int pick;
        s_valid = 1'b0;
        m_ready = 1'b0;
        s_data = '0;
        s_ready_seen = 1'b0;
        fail_count = 0;
        send_idle = 38;
        recv_idle = 62;
        tm_head = NIL;
        tm_tail = NIL;
        for (i = 0; i < NSLOT; i++) begin
            tm_time[i] = '0;
            tm_linked[i] = 1'b0;
            tm_next[i] = NIL;
            tm_prev[i] = NIL;
        end
        aresetn = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed
        pending_beats.push_back(make_beat(CMD_TICK, 0, 32'hFFFF_FFFF));
        pending_beats.push_back(make_beat(CMD_DELETE, 5, 0));
        pending_beats.push_back(make_beat(CMD_ADJUST, 63, 0));
        pending_beats.push_back(make_beat(CMD_ADD, 0, 32'hFFFF_FFFF));
        pending_beats.push_back(make_beat(CMD_ADD, 63, 0));
        pending_beats.push_back(make_beat(CMD_ADD, 7, 100));
        pending_beats.push_back(make_beat(CMD_ADD, 8, 100));
        pending_beats.push_back(make_beat(CMD_ADD, 9, 100));
        pending_beats.push_back(make_beat(CMD_ADD, 7, 5));
        pending_beats.push_back(make_beat(CMD_ADJUST, 7, 50));
        pending_beats.push_back(make_beat(CMD_ADJUST, 8, 100));
        pending_beats.push_back(make_beat(CMD_ADJUST, 63, 200));
        pending_beats.push_back(make_beat(CMD_DELETE, 9, 0));
        pending_beats.push_back(make_beat(CMD_TICK, 0, 99));
        pending_beats.push_back(make_beat(CMD_TICK, 42, 100));
        pending_beats.push_back(make_beat(CMD_TICK, 0, 32'hFFFF_FFFE));
        pending_beats.push_back(make_beat(CMD_TICK, 0, 32'hFFFF_FFFF));
        for (i = 0; i < NSLOT; i++)
            pending_beats.push_back(make_beat(CMD_ADD, i, 32'd1000 - i[31:0] % 3));
        pending_beats.push_back(make_beat(CMD_TICK, 0, 32'd1000));
        wait_drained();

        // random phases
        now = 0;
        for (phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 38 : (phase == 1) ? 62 : 0;
            recv_idle = (phase == 0) ? 62 : (phase == 1) ? 38 : 0;
            for (i = 0; i < 80; i++) begin
                pick = $urandom_range(9);
                if (pick < 4)
                    pending_beats.push_back(make_beat(CMD_ADD, $urandom_range(63), rand_time(now)));
                else if (pick < 6)
                    pending_beats.push_back(make_beat(CMD_ADJUST, $urandom_range(63),
                                                      rand_time(now)));
                else if (pick < 7)
                    pending_beats.push_back(make_beat(CMD_DELETE, $urandom_range(63), $urandom()));
                else begin
                    now = now + $urandom_range(40);
                    pending_beats.push_back(make_beat(CMD_TICK, $urandom_range(63),
                                                      ($urandom_range(19) == 0) ? $urandom() : now));
                end
            end
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
